// ===== hw/rtl/ica_pkg.sv =====
// ----------------------------------------------------------------------------
// ica_pkg
// Types, constants and helper functions for the complementary attitude filter.
// ----------------------------------------------------------------------------
package ica_pkg;

    localparam int DIV_W   = 42;
    localparam int DIVB_W  = 15;
    localparam int CORD_W  = 34;
    localparam int ANG_W   = 27;
    localparam int SQ_W    = 61;
    localparam int CORD_STEPS = 16;

    // reciprocal divide: ceil(2^RCP_SH / b) is exact for any 42-bit numerator
    localparam int RCP_W      = 52;
    localparam int RCP_SH     = 57;
    localparam int DIV_CHUNK  = 14;
    localparam int DIV_CHUNKS = 3;

    localparam logic [DIVB_W-1:0] DIVB_RATE = 15'd262;
    localparam logic [DIVB_W-1:0] DIVB_TEMP = 15'd17000;
    localparam logic [DIVB_W-1:0] DIVB_STEP = 15'd2000;
    localparam logic [DIVB_W-1:0] DIVB_FILT = 15'd50;

    localparam logic [RCP_W-1:0] RCP_RATE =
        RCP_W'(((64'd1 << RCP_SH) + 64'd261) / 64'd262);
    localparam logic [RCP_W-1:0] RCP_TEMP =
        RCP_W'(((64'd1 << RCP_SH) + 64'd16999) / 64'd17000);
    localparam logic [RCP_W-1:0] RCP_STEP =
        RCP_W'(((64'd1 << RCP_SH) + 64'd1999) / 64'd2000);
    localparam logic [RCP_W-1:0] RCP_FILT =
        RCP_W'(((64'd1 << RCP_SH) + 64'd49) / 64'd50);

    localparam logic signed [ANG_W-1:0] DEG180 = 27'sd11796480;
    localparam logic signed [27:0]      DEG360 = 28'sd23592960;

    localparam logic [1:0] CFG_OFF_X = 2'd0;
    localparam logic [1:0] CFG_OFF_Y = 2'd1;
    localparam logic [1:0] CFG_OFF_Z = 2'd2;
    localparam logic [1:0] CFG_BIAS  = 2'd3;

    localparam logic [3:0] JOB_RX    = 4'd0;
    localparam logic [3:0] JOB_RY    = 4'd1;
    localparam logic [3:0] JOB_RZ    = 4'd2;
    localparam logic [3:0] JOB_TEMP  = 4'd3;
    localparam logic [3:0] JOB_DX    = 4'd4;
    localparam logic [3:0] JOB_DY    = 4'd5;
    localparam logic [3:0] JOB_DZ    = 4'd6;
    localparam logic [3:0] JOB_PITCH = 4'd7;
    localparam logic [3:0] JOB_ROLL  = 4'd8;

    typedef struct packed {
        logic signed [15:0] ax;
        logic signed [15:0] ay;
        logic signed [15:0] az;
        logic signed [15:0] rx;
        logic signed [15:0] ry;
        logic signed [15:0] rz;
        logic signed [15:0] temp;
        logic [7:0]         ms;
    } item_t;

    typedef struct packed {
        logic signed [25:0] off_x;
        logic signed [25:0] off_y;
        logic signed [25:0] off_z;
        logic               bias_done;
    } cfg_t;

    typedef struct packed {
        logic [24:0]        yaw;
        logic signed [31:0] roll;
        logic signed [31:0] pitch;
        logic signed [16:0] temp;
        logic signed [26:0] rz;
        logic signed [26:0] ry;
        logic signed [26:0] rx;
        logic signed [15:0] az;
        logic signed [15:0] ay;
        logic signed [15:0] ax;
    } result_t;

    function automatic logic [21:0] atan_tab(input logic [3:0] idx);
        logic [21:0] v;
        case (idx)
            4'd0:    v = 22'd2949120;
            4'd1:    v = 22'd1740967;
            4'd2:    v = 22'd919879;
            4'd3:    v = 22'd466945;
            4'd4:    v = 22'd234379;
            4'd5:    v = 22'd117304;
            4'd6:    v = 22'd58666;
            4'd7:    v = 22'd29335;
            4'd8:    v = 22'd14668;
            4'd9:    v = 22'd7334;
            4'd10:   v = 22'd3667;
            4'd11:   v = 22'd1833;
            4'd12:   v = 22'd917;
            4'd13:   v = 22'd458;
            4'd14:   v = 22'd229;
            4'd15:   v = 22'd115;
            default: v = 22'd0;
        endcase
        return v;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [DIV_W-1:0] v);
        logic signed [31:0] r;
        if (v > 42'sd2147483647) begin
            r = 32'sh7fffffff;
        end else if (v < -42'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

// ===== hw/rtl/ica_front.sv =====
// ----------------------------------------------------------------------------
// ica_front
// Accepts sample requests, clamps the time step and queues them (two deep).
// ----------------------------------------------------------------------------
module ica_front
    import ica_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [127:0] s_tdata,
    output logic         q_valid,
    output item_t        q_item,
    input  logic         q_pop
);

    item_t      mem [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       push;
    item_t      in_item;

    // time steps over 200 ms count as 50 ms
    always_comb begin
        in_item.ax   = s_tdata[15:0];
        in_item.ay   = s_tdata[31:16];
        in_item.az   = s_tdata[47:32];
        in_item.rx   = s_tdata[63:48];
        in_item.ry   = s_tdata[79:64];
        in_item.rz   = s_tdata[95:80];
        in_item.temp = s_tdata[111:96];
        in_item.ms   = (s_tdata[127:112] > 16'd200) ? 8'd50 : s_tdata[119:112];
    end

    assign s_tready = (cnt_reg != 2'd2);
    assign push     = s_tvalid && s_tready;
    assign q_valid  = (cnt_reg != 2'd0);

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = q_pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + {1'b0, push} - {1'b0, q_pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= in_item;
        end
    end

    assign q_item = mem[rd_ptr_reg];

endmodule

// ===== hw/rtl/ica_div.sv =====
// ----------------------------------------------------------------------------
// ica_div
// Signed floor divider by one of the fixed divisors, by a reciprocal multiply
// taken in three 14-bit slices of the numerator.
// ----------------------------------------------------------------------------
module ica_div
    import ica_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    start,
    input  logic signed [DIV_W-1:0] dividend,
    input  logic [DIVB_W-1:0]       divisor,
    output logic                    done,
    output logic signed [DIV_W-1:0] quot
);

    logic [DIV_W-1:0]          num_reg;
    logic [RCP_W-1:0]          rcp_reg;
    logic [DIV_W+RCP_W-1:0]    acc_reg;
    logic                      neg_reg;
    logic [1:0]                cnt_reg;
    logic                      busy_reg;
    logic                      done_reg;
    logic [DIV_W-1:0]          mag;
    logic [RCP_W-1:0]          rcp;
    logic [RCP_W+DIV_CHUNK-1:0] part;
    logic [DIV_W-1:0]          quo;

    // floor of a negative quotient: divide |a| + b - 1
    assign mag = dividend[DIV_W-1] ?
                 ($unsigned(-dividend) + {{(DIV_W-DIVB_W){1'b0}}, divisor} - 42'd1) :
                 $unsigned(dividend);

    always_comb begin
        case (divisor)
            DIVB_RATE: rcp = RCP_RATE;
            DIVB_TEMP: rcp = RCP_TEMP;
            DIVB_STEP: rcp = RCP_STEP;
            DIVB_FILT: rcp = RCP_FILT;
            default:   rcp = '0;
        endcase
    end

    // top slice first; the sum is shifted up one slice per step
    assign part = {{DIV_CHUNK{1'b0}}, rcp_reg} *
                  {{RCP_W{1'b0}}, num_reg[DIV_W-1 -: DIV_CHUNK]};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= 2'd0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 2'd1;
                if (cnt_reg == 2'(DIV_CHUNKS - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            num_reg <= mag;
            rcp_reg <= rcp;
            acc_reg <= '0;
            neg_reg <= dividend[DIV_W-1];
        end else if (busy_reg) begin
            acc_reg <= {acc_reg[DIV_W+RCP_W-DIV_CHUNK-1:0], {DIV_CHUNK{1'b0}}} +
                       {{(DIV_W-DIV_CHUNK){1'b0}}, part};
            num_reg <= {num_reg[DIV_W-DIV_CHUNK-1:0], {DIV_CHUNK{1'b0}}};
        end
    end

    assign quo  = {{(RCP_SH-RCP_W){1'b0}}, acc_reg[DIV_W+RCP_W-1:RCP_SH]};
    assign done = done_reg;
    assign quot = neg_reg ? -$signed(quo) : $signed(quo);

endmodule

// ===== hw/rtl/ica_cordic.sv =====
// ----------------------------------------------------------------------------
// ica_cordic
// Iterative vectoring CORDIC atan2, one micro-rotation per cycle.
// ----------------------------------------------------------------------------
module ica_cordic
    import ica_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     start,
    input  logic signed [CORD_W-1:0] y_in,
    input  logic signed [CORD_W-1:0] x_in,
    output logic                     done,
    output logic signed [ANG_W-1:0]  angle
);

    logic signed [CORD_W-1:0] x_reg, y_reg;
    logic signed [ANG_W-1:0]  z_reg;
    logic [3:0]               i_reg;
    logic                     busy_reg;
    logic                     done_reg;
    logic signed [CORD_W-1:0] dx, dy;
    logic signed [ANG_W-1:0]  tab;
    logic                     ypos;

    assign dx   = y_reg >>> i_reg;
    assign dy   = x_reg >>> i_reg;
    assign tab  = $signed({5'b0, atan_tab(i_reg)});
    assign ypos = !y_reg[CORD_W-1] && (y_reg != '0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            i_reg    <= 4'd0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                i_reg <= 4'd0;
                if (y_in == '0) begin
                    done_reg <= 1'b1;
                end else begin
                    busy_reg <= 1'b1;
                end
            end else if (busy_reg) begin
                i_reg <= i_reg + 4'd1;
                if (i_reg == 4'(CORD_STEPS - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            if (y_in == '0) begin
                z_reg <= x_in[CORD_W-1] ? -DEG180 : '0;
            end else if (x_in[CORD_W-1]) begin
                // left half plane: rotate by 180 first
                x_reg <= -x_in;
                y_reg <= -y_in;
                z_reg <= y_in[CORD_W-1] ? -DEG180 : DEG180;
            end else begin
                x_reg <= x_in;
                y_reg <= y_in;
                z_reg <= '0;
            end
        end else if (busy_reg) begin
            if (ypos) begin
                x_reg <= x_reg + dx;
                y_reg <= y_reg - dy;
                z_reg <= z_reg + tab;
            end else begin
                x_reg <= x_reg - dx;
                y_reg <= y_reg + dy;
                z_reg <= z_reg - tab;
            end
        end
    end

    assign done  = done_reg;
    assign angle = z_reg;

endmodule

// ===== hw/rtl/ica_back.sv =====
// ----------------------------------------------------------------------------
// ica_back
// Sequencer: scaling, time step, tilt angles and attitude update per sample.
// ----------------------------------------------------------------------------
module ica_back
    import ica_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  cfg_t    cfg,
    input  logic    q_valid,
    input  item_t   q_item,
    output logic    q_pop,
    output logic    m_valid,
    input  logic    m_ready,
    output result_t m_res
);

    typedef enum logic [10:0] {
        ST_IDLE   = 11'b00000000001,
        ST_SQUARE = 11'b00000000010,
        ST_CHECK  = 11'b00000000100,
        ST_MULMS  = 11'b00000001000,
        ST_DIVSET = 11'b00000010000,
        ST_DIVRUN = 11'b00000100000,
        ST_SQRT   = 11'b00001000000,
        ST_CORD_P = 11'b00010000000,
        ST_CORD_R = 11'b00100000000,
        ST_UPDATE = 11'b01000000000,
        ST_OUT    = 11'b10000000000
    } state_t;

    state_t                  state_reg;
    item_t                   item_reg;
    logic [3:0]              job_reg;
    logic [1:0]              sq_cnt_reg;
    logic [31:0]             sq_reg [3];
    logic                    plaus_reg;
    logic                    init_reg;
    logic signed [26:0]      rate_reg [3];
    logic signed [26:0]      d_reg [3];
    logic signed [16:0]      temp_reg;
    logic signed [35:0]      prod_reg;
    logic [SQ_W-1:0]         v_reg, r_reg, bit_reg;
    logic signed [ANG_W-1:0] pa_reg, ra_reg;
    logic signed [DIV_W-1:0] fq_reg [2];
    logic signed [31:0]      pitch_reg, roll_reg;
    logic [24:0]             yaw_reg;
    logic                    m_valid_reg;
    result_t                 res_reg;

    logic signed [31:0]       sq_a;
    logic [33:0]              m2;
    logic [38:0]              m25;
    logic signed [DIV_W-1:0]  dv_a;
    logic [DIVB_W-1:0]        dv_b;
    logic                     dv_start;
    logic                     dv_done;
    logic signed [DIV_W-1:0]  dv_q;
    logic signed [15:0]       raw_r;
    logic signed [30:0]       tmul;
    logic signed [32:0]       fsum_p, fsum_r, fsum;
    logic signed [DIV_W-1:0]  fn;
    logic signed [26:0]       rate_sel;
    logic [SQ_W-1:0]          sq_t;
    logic                     cd_start;
    logic                     cd_done;
    logic signed [CORD_W-1:0] cd_y, cd_x;
    logic signed [ANG_W-1:0]  cd_angle;
    logic signed [27:0]       ysum;
    logic [24:0]              yaw_new;
    logic signed [31:0]       pitch_new, roll_new;
    logic signed [26:0]       off_sel;

    always_comb begin
        case (sq_cnt_reg)
            2'd0:    sq_a = 32'(item_reg.ax);
            2'd1:    sq_a = 32'(item_reg.ay);
            default: sq_a = 32'(item_reg.az);
        endcase
    end

    assign m2  = {2'b0, sq_reg[0]} + {2'b0, sq_reg[1]} + {2'b0, sq_reg[2]};
    assign m25 = ({5'b0, m2} << 4) + ({5'b0, m2} << 3) + {5'b0, m2};

    // divider operands: a = 2n + d, b = 2d gives round-half-up
    always_comb begin
        case (job_reg)
            JOB_RX:  raw_r = item_reg.rx;
            JOB_RY:  raw_r = item_reg.ry;
            default: raw_r = item_reg.rz;
        endcase
    end

    assign tmul   = 31'(item_reg.temp) * 31'sd6400;
    assign fsum_p = 33'(pitch_reg) + 33'(d_reg[0]);
    assign fsum_r = 33'(roll_reg) + 33'(d_reg[1]);
    assign fsum   = (job_reg == JOB_PITCH) ? fsum_p : fsum_r;
    assign fn     = (42'(fsum) <<< 4) + (42'(fsum) <<< 3) +
                    ((job_reg == JOB_PITCH) ? 42'(pa_reg) : 42'(ra_reg));

    always_comb begin
        case (job_reg)
            JOB_RX, JOB_RY, JOB_RZ: begin
                dv_a = (42'(raw_r) <<< 18) + 42'sd131;
                dv_b = 15'd262;
            end
            JOB_TEMP: begin
                dv_a = ((42'(tmul) + 42'sd79489280) <<< 1) + 42'sd8500;
                dv_b = 15'd17000;
            end
            JOB_DX, JOB_DY, JOB_DZ: begin
                dv_a = (42'(prod_reg) <<< 1) + 42'sd1000;
                dv_b = 15'd2000;
            end
            JOB_PITCH, JOB_ROLL: begin
                dv_a = (fn <<< 1) + 42'sd25;
                dv_b = 15'd50;
            end
            default: begin
                dv_a = '0;
                dv_b = 15'd1;
            end
        endcase
    end

    always_comb begin
        case (job_reg)
            JOB_DX:  rate_sel = rate_reg[0];
            JOB_DY:  rate_sel = rate_reg[1];
            default: rate_sel = rate_reg[2];
        endcase
        case (job_reg)
            JOB_RX:  off_sel = 27'(cfg.off_x);
            JOB_RY:  off_sel = 27'(cfg.off_y);
            default: off_sel = 27'(cfg.off_z);
        endcase
    end

    assign dv_start = (state_reg == ST_DIVSET);

    ica_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (dv_start),
        .dividend (dv_a),
        .divisor  (dv_b),
        .done     (dv_done),
        .quot     (dv_q)
    );

    assign sq_t = r_reg + bit_reg;

    // pitch operand pair first, roll pair once pitch is done
    assign cd_start = ((state_reg == ST_SQRT) && (bit_reg == '0)) ||
                      ((state_reg == ST_CORD_P) && cd_done);
    always_comb begin
        if (state_reg == ST_SQRT) begin
            cd_y = 34'(item_reg.ay) <<< 14;
            cd_x = $signed({4'b0, r_reg[29:0]});
        end else begin
            cd_y = (-34'(item_reg.ax)) <<< 14;
            cd_x = 34'(item_reg.az) <<< 14;
        end
    end

    ica_cordic u_cordic (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cd_start),
        .y_in    (cd_y),
        .x_in    (cd_x),
        .done    (cd_done),
        .angle   (cd_angle)
    );

    always_comb begin
        ysum = 28'($signed({1'b0, yaw_reg})) + 28'(d_reg[2]);
        if (ysum < 0) begin
            ysum = ysum + DEG360;
        end else if (ysum >= DEG360) begin
            ysum = ysum - DEG360;
        end
        yaw_new = ysum[24:0];
        if (!plaus_reg) begin
            pitch_new = sat32(42'(fsum_p));
            roll_new  = sat32(42'(fsum_r));
        end else if (init_reg) begin
            pitch_new = 32'(pa_reg);
            roll_new  = 32'(ra_reg);
        end else begin
            pitch_new = sat32(fq_reg[0]);
            roll_new  = sat32(fq_reg[1]);
        end
    end

    assign q_pop = (state_reg == ST_IDLE) && q_valid;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            job_reg     <= JOB_RX;
            sq_cnt_reg  <= 2'd0;
            m_valid_reg <= 1'b0;
            pitch_reg   <= '0;
            roll_reg    <= '0;
            yaw_reg     <= '0;
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    if (q_valid) begin
                        sq_cnt_reg <= 2'd0;
                        state_reg  <= ST_SQUARE;
                    end
                end
                ST_SQUARE: begin
                    sq_cnt_reg <= sq_cnt_reg + 2'd1;
                    if (sq_cnt_reg == 2'd2) begin
                        state_reg <= ST_CHECK;
                    end
                end
                ST_CHECK: begin
                    job_reg   <= JOB_RX;
                    state_reg <= ST_DIVSET;
                end
                ST_MULMS: begin
                    state_reg <= ST_DIVSET;
                end
                ST_DIVSET: begin
                    state_reg <= ST_DIVRUN;
                end
                ST_DIVRUN: begin
                    if (dv_done) begin
                        case (job_reg)
                            JOB_TEMP, JOB_DX, JOB_DY: begin
                                job_reg   <= job_reg + 4'd1;
                                state_reg <= ST_MULMS;
                            end
                            JOB_DZ: begin
                                state_reg <= plaus_reg ? ST_SQRT : ST_UPDATE;
                            end
                            JOB_ROLL: begin
                                state_reg <= ST_UPDATE;
                            end
                            default: begin
                                job_reg   <= job_reg + 4'd1;
                                state_reg <= ST_DIVSET;
                            end
                        endcase
                    end
                end
                ST_SQRT: begin
                    if (bit_reg == '0) begin
                        state_reg <= ST_CORD_P;
                    end
                end
                ST_CORD_P: begin
                    if (cd_done) begin
                        state_reg <= ST_CORD_R;
                    end
                end
                ST_CORD_R: begin
                    if (cd_done) begin
                        if (init_reg) begin
                            state_reg <= ST_UPDATE;
                        end else begin
                            job_reg   <= JOB_PITCH;
                            state_reg <= ST_DIVSET;
                        end
                    end
                end
                ST_UPDATE: begin
                    pitch_reg   <= pitch_new;
                    roll_reg    <= roll_new;
                    yaw_reg     <= yaw_new;
                    m_valid_reg <= 1'b1;
                    state_reg   <= ST_OUT;
                end
                ST_OUT: begin
                    if (m_ready) begin
                        m_valid_reg <= 1'b0;
                        state_reg   <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                item_reg <= q_item;
            end
            ST_SQUARE: begin
                sq_reg[sq_cnt_reg] <= $unsigned(sq_a * sq_a);
            end
            ST_CHECK: begin
                plaus_reg <= (m25 > 39'(64'd16 << 26)) && (m25 < 39'(64'd36 << 26));
                init_reg  <= !cfg.bias_done || ((pitch_reg == '0) && (roll_reg == '0));
                v_reg     <= {1'b0, sq_reg[0] + sq_reg[2], 28'b0};
                r_reg     <= '0;
                bit_reg   <= SQ_W'(1) << 60;
            end
            ST_MULMS: begin
                prod_reg <= 36'(rate_sel) * 36'($signed({1'b0, item_reg.ms}));
            end
            ST_DIVRUN: begin
                if (dv_done) begin
                    case (job_reg)
                        JOB_RX:    rate_reg[0] <= dv_q[26:0] - off_sel;
                        JOB_RY:    rate_reg[1] <= dv_q[26:0] - off_sel;
                        JOB_RZ:    rate_reg[2] <= dv_q[26:0] - off_sel;
                        JOB_TEMP:  temp_reg    <= dv_q[16:0];
                        JOB_DX:    d_reg[0]    <= dv_q[26:0];
                        JOB_DY:    d_reg[1]    <= dv_q[26:0];
                        JOB_DZ:    d_reg[2]    <= dv_q[26:0];
                        JOB_PITCH: fq_reg[0]   <= dv_q;
                        JOB_ROLL:  fq_reg[1]   <= dv_q;
                        default:   temp_reg    <= temp_reg;
                    endcase
                end
            end
            ST_SQRT: begin
                if (bit_reg != '0) begin
                    if (v_reg >= sq_t) begin
                        v_reg <= v_reg - sq_t;
                        r_reg <= (r_reg >> 1) + bit_reg;
                    end else begin
                        r_reg <= r_reg >> 1;
                    end
                    bit_reg <= bit_reg >> 2;
                end
            end
            ST_CORD_P: begin
                if (cd_done) begin
                    pa_reg <= cd_angle;
                end
            end
            ST_CORD_R: begin
                if (cd_done) begin
                    ra_reg <= cd_angle;
                end
            end
            ST_UPDATE: begin
                res_reg.ax    <= item_reg.ax;
                res_reg.ay    <= item_reg.ay;
                res_reg.az    <= item_reg.az;
                res_reg.rx    <= rate_reg[0];
                res_reg.ry    <= rate_reg[1];
                res_reg.rz    <= rate_reg[2];
                res_reg.temp  <= temp_reg;
                res_reg.pitch <= pitch_new;
                res_reg.roll  <= roll_new;
                res_reg.yaw   <= yaw_new;
            end
            default: begin
                res_reg <= res_reg;
            end
        endcase
    end

    assign m_valid = m_valid_reg;
    assign m_res   = res_reg;

endmodule

// ===== hw/rtl/imu_complementary_attitude_top.sv =====
// ----------------------------------------------------------------------------
// imu_complementary_attitude_top
// Complementary-filter pitch/roll and integrated yaw from six-axis samples.
// ----------------------------------------------------------------------------
// One result per sample request. The path that a sample takes from the core
// picking up a request to the result leaving with m_tready high depends on
// whether the acceleration is outside 0.8..1.2 g, gives a direct tilt update
// or is filtered (a zero CORDIC y operand skips that run's micro-rotations).
// Each division by a fixed constant is a three-step reciprocal multiply, seven
// to nine per sample, with a multiply state before each of the three time-step
// divisions; the square root and two CORDIC runs make up the tilt path. A
// two-deep queue takes requests while the core works and while a result waits.
// The user must write offsets and bias_done through cfg_we/cfg_index/cfg_wdata
// only while the block is idle; the block itself does not enforce this.
module imu_complementary_attitude_top
    import ica_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // ax, ay, az, rate x, rate y, rate z, temp, elapsed_ms (16 bits each)
    input  logic [127:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // ax, ay, az, rate_dx, rate_dy, rate_dz, temp_c, pitch, roll, yaw, zero pad
    output logic [239:0] m_tdata,
    input  logic         cfg_we,
    input  logic [1:0]   cfg_index,
    input  logic [25:0]  cfg_wdata
);

    cfg_t    cfg_reg;
    logic    q_valid;
    item_t   q_item;
    logic    q_pop;
    result_t res;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_OFF_X: cfg_reg.off_x     <= cfg_wdata;
                CFG_OFF_Y: cfg_reg.off_y     <= cfg_wdata;
                CFG_OFF_Z: cfg_reg.off_z     <= cfg_wdata;
                CFG_BIAS:  cfg_reg.bias_done <= cfg_wdata[0];
                default:   cfg_reg           <= cfg_reg;
            endcase
        end
    end

    ica_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop)
    );

    ica_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg_reg),
        .q_valid (q_valid),
        .q_item  (q_item),
        .q_pop   (q_pop),
        .m_valid (m_tvalid),
        .m_ready (m_tready),
        .m_res   (res)
    );

    assign m_tdata = {5'b0, res};

endmodule
